// ===== hdl/bmhq_pkg.sv =====
// Package for the binary min-heap queue: sizes, codes and word types.
// Used by every module of the block; depends on nothing else.
package bmhq_pkg;

  localparam int unsigned HEAP_DEPTH  = 256;
  localparam int unsigned KEY_BITS    = 16;
  localparam int unsigned HANDLE_BITS = 16;
  localparam int unsigned ADDR_BITS   = $clog2(HEAP_DEPTH);
  localparam int unsigned CNT_BITS    = ADDR_BITS + 1;

  typedef enum logic {
    FUNC_PUSH = 1'b0,
    FUNC_POP  = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef logic [KEY_BITS-1:0]    key_t;
  typedef logic [HANDLE_BITS-1:0] handle_t;
  typedef logic [ADDR_BITS-1:0]   addr_t;
  typedef logic [CNT_BITS-1:0]    cnt_t;

  typedef struct packed {
    key_t    key;
    handle_t handle;
  } entry_t;

  typedef struct packed {
    func_e   func;
    key_t    priority_key;
    handle_t item_handle;
  } req_t;

  typedef struct packed {
    key_t    out_key;
    handle_t out_handle;
    status_e status;
    cnt_t    entry_count;
  } rsp_t;

endpackage

// ===== hdl/bmhq_mem.sv =====
// Heap storage: one write port and two registered read ports.
// Depends on bmhq_pkg for the entry and address types.
module bmhq_mem
  import bmhq_pkg::*;
(
  input  logic   clk_i,
  input  logic   we_i,
  input  addr_t  waddr_i,
  input  entry_t wdata_i,
  input  addr_t  raddr_a_i,
  input  addr_t  raddr_b_i,
  output entry_t rdata_a_o,
  output entry_t rdata_b_o
);

  entry_t mem_q [HEAP_DEPTH];
  entry_t rdata_a_q;
  entry_t rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== hdl/bmhq_cmp.sv =====
// Shared key comparator for both sift directions of the heap.
// Depends on bmhq_pkg for the key type.
module bmhq_cmp
  import bmhq_pkg::*;
(
  input  logic down_i,
  input  key_t a_key_i,
  input  key_t b_key_i,
  input  logic b_ok_i,
  input  key_t m_key_i,
  output logic pick_b_o,
  output logic stop_o
);

  key_t sel_key;
  key_t lhs;
  key_t rhs;

  // The right child wins only when it exists and is strictly smaller.
  assign pick_b_o = b_ok_i && (b_key_i < a_key_i);
  assign sel_key  = pick_b_o ? b_key_i : a_key_i;

  // Going up we stop when the parent is not above the moving key;
  // going down we stop when the moving key is not above the chosen child.
  assign lhs    = down_i ? m_key_i : sel_key;
  assign rhs    = down_i ? sel_key : m_key_i;
  assign stop_o = (lhs <= rhs);

endmodule

// ===== hdl/binary_min_heap_queue.sv =====
// Binary min-heap priority queue of (key, handle) words, built around a
// small sequencer, one shared comparator and a heap memory with registered reads.
// A push walks up from the new leaf; a pop loads the root and the last entry, then walks
// down, one tree level a cycle; a dropped push or a pop on an empty heap goes straight to done_o.
// busy falls in the done_o cycle, where the next word may start; no new word is taken before then.
// Reset (rst_ni low, asynchronous) empties the heap without a clearing pass; no result stalls.
module binary_min_heap_queue
  import bmhq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  req_t req_i,
  output logic busy,
  output logic done_o,
  output rsp_t rsp_o
);

  // Sequencer states. S_UP walks a pushed word toward the root, S_LOAD
  // takes the root and last entry of a pop, S_DOWN walks the moved entry
  // toward the leaves and S_LAST writes the moving entry at its hole.
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_UP   = 5'b00010,
    S_LOAD = 5'b00100,
    S_DOWN = 5'b01000,
    S_LAST = 5'b10000
  } state_e;

  state_e state_q, state_d;
  addr_t  pos_q, pos_d;
  cnt_t   fill_q, fill_d;
  entry_t mov_q, mov_d;
  rsp_t   res_q, res_d;
  logic   done_q, done_d;

  logic   mem_we;
  addr_t  mem_waddr;
  entry_t mem_wdata;
  addr_t  raddr_a;
  addr_t  raddr_b;
  entry_t rdata_a;
  entry_t rdata_b;

  logic   cmp_down;
  logic   cmp_b_ok;
  logic   pick_b;
  logic   stop;

  logic   accept;
  addr_t  up_addr;
  cnt_t   lc_cnt;
  cnt_t   rc_cnt;
  addr_t  pick_addr;
  cnt_t   nlc_cnt;
  cnt_t   nrc_cnt;
  cnt_t   last_cnt;

  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q != S_IDLE);

  // Index arithmetic of the tree: parent of the hole, children of the hole
  // and children of the child that is about to become the hole.
  assign up_addr   = addr_t'((pos_q - addr_t'(1)) >> 1);
  assign lc_cnt    = {pos_q, 1'b1};
  assign rc_cnt    = lc_cnt + cnt_t'(1);
  assign pick_addr = pick_b ? rc_cnt[ADDR_BITS-1:0] : lc_cnt[ADDR_BITS-1:0];
  assign nlc_cnt   = {pick_addr, 1'b1};
  assign nrc_cnt   = nlc_cnt + cnt_t'(1);
  assign last_cnt  = fill_q - cnt_t'(1);

  assign cmp_down = (state_q == S_DOWN);
  assign cmp_b_ok = cmp_down && (rc_cnt < fill_q);

  bmhq_cmp u_cmp (
    .down_i   (cmp_down),
    .a_key_i  (rdata_a.key),
    .b_key_i  (rdata_b.key),
    .b_ok_i   (cmp_b_ok),
    .m_key_i  (mov_q.key),
    .pick_b_o (pick_b),
    .stop_o   (stop)
  );

  bmhq_mem u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    fill_d    = fill_q;
    mov_d     = mov_q;
    res_d     = res_q;
    done_d    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = pos_q;
    mem_wdata = mov_q;
    raddr_a   = '0;
    raddr_b   = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d.out_key    = '0;
          res_d.out_handle = '0;
          res_d.status     = ST_DONE;
          if (req_i.func == FUNC_PUSH) begin
            if (fill_q >= cnt_t'(HEAP_DEPTH)) begin
              // A full heap drops the word and reports it at once.
              res_d.status      = ST_FULL;
              res_d.entry_count = fill_q;
              done_d            = 1'b1;
            end else begin
              mov_d.key         = req_i.priority_key;
              mov_d.handle      = req_i.item_handle;
              fill_d            = fill_q + cnt_t'(1);
              res_d.entry_count = fill_q + cnt_t'(1);
              pos_d             = fill_q[ADDR_BITS-1:0];
              if (fill_q == '0) begin
                state_d = S_LAST;
              end else begin
                raddr_a = addr_t'(last_cnt >> 1);
                state_d = S_UP;
              end
            end
          end else begin
            if (fill_q == '0) begin
              res_d.status      = ST_EMPTY;
              res_d.entry_count = '0;
              done_d            = 1'b1;
            end else begin
              // Fetch the root and the last entry together.
              raddr_a           = '0;
              raddr_b           = last_cnt[ADDR_BITS-1:0];
              fill_d            = last_cnt;
              res_d.entry_count = last_cnt;
              pos_d             = '0;
              state_d           = S_LOAD;
            end
          end
        end
      end
      S_UP: begin
        if (stop) begin
          mem_we  = 1'b1;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          // Move the parent down into the hole and fetch the next parent.
          mem_we    = 1'b1;
          mem_wdata = rdata_a;
          pos_d     = up_addr;
          if (up_addr == '0) begin
            state_d = S_LAST;
          end else begin
            raddr_a = addr_t'((up_addr - addr_t'(1)) >> 1);
          end
        end
      end
      S_LOAD: begin
        res_d.out_key    = rdata_a.key;
        res_d.out_handle = rdata_a.handle;
        mov_d            = rdata_b;
        if (fill_q > cnt_t'(1)) begin
          raddr_a = addr_t'(1);
          raddr_b = addr_t'(2);
          state_d = S_DOWN;
        end else begin
          state_d = S_LAST;
        end
      end
      S_DOWN: begin
        if (stop) begin
          mem_we  = 1'b1;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          // Move the smaller child up into the hole and fetch its children.
          mem_we    = 1'b1;
          mem_wdata = pick_b ? rdata_b : rdata_a;
          pos_d     = pick_addr;
          if (nlc_cnt < fill_q) begin
            raddr_a = nlc_cnt[ADDR_BITS-1:0];
            raddr_b = nrc_cnt[ADDR_BITS-1:0];
          end else begin
            state_d = S_LAST;
          end
        end
      end
      S_LAST: begin
        mem_we  = 1'b1;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    mov_q <= mov_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign rsp_o  = res_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= cnt_t'(HEAP_DEPTH))
    else $error("heap fill count exceeds its depth");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result word shown while the sequencer is still busy");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy || done_o))
    else $error("accepted word neither in work nor finished");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == ST_FULL) |-> (rsp_o.entry_count == cnt_t'(HEAP_DEPTH)))
    else $error("dropped push reported with a count below the depth");

  a_empty_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == ST_EMPTY) |->
      (rsp_o.entry_count == '0 && rsp_o.out_key == '0 && rsp_o.out_handle == '0))
    else $error("pop on empty heap reported a nonzero word");
`endif

endmodule

// ===== verif/binary_min_heap_queue_tb.sv =====
// Self-checking testbench for binary_min_heap_queue: push and pop words with random gaps,
// checked against a behavioral heap kept in a small scoreboard class.
// Depends on bmhq_pkg and on the binary_min_heap_queue RTL.
module binary_min_heap_queue_tb
  import bmhq_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_PERIOD  = 10;
  // A pop walks at most ADDR_BITS levels of the tree, so this
  // is a comfortable bound on the time from one accepted word to its result.
  localparam int unsigned LAT_CYCLES  = 2 * ADDR_BITS + 4;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RAND_WORDS  = 30;

  // The scoreboard keeps its own heap. Every accepted word updates it at once
  // and queues the result the block must give for that word; every result the
  // block gives is checked against the oldest queued one.
  class heap_scoreboard;
    key_t        keys[HEAP_DEPTH];
    handle_t     handles[HEAP_DEPTH];
    int unsigned fill;
    rsp_t        pending_rsps[$];
    int unsigned errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function void note_word(req_t w);
      rsp_t        r;
      int unsigned pos;
      int unsigned up;
      int unsigned lc;
      int unsigned pick;
      key_t        mkey;
      handle_t     mhandle;
      r        = '0;
      r.status = ST_DONE;
      if (w.func == FUNC_PUSH) begin
        if (fill >= HEAP_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // Sift up; a parent with an equal key stops the walk.
          pos = fill;
          fill++;
          while (pos > 0) begin
            up = (pos - 1) / 2;
            if (keys[up] <= w.priority_key) break;
            keys[pos]    = keys[up];
            handles[pos] = handles[up];
            pos          = up;
          end
          keys[pos]    = w.priority_key;
          handles[pos] = w.item_handle;
        end
      end else if (fill == 0) begin
        r.status = ST_EMPTY;
      end else begin
        // Take the root, move the last entry up and sift it down. The right
        // child wins only when strictly smaller; equal keys stop the walk.
        r.out_key    = keys[0];
        r.out_handle = handles[0];
        fill--;
        mkey    = keys[fill];
        mhandle = handles[fill];
        pos     = 0;
        while (2 * pos + 1 < fill) begin
          lc   = 2 * pos + 1;
          pick = lc;
          if (lc + 1 < fill && keys[lc + 1] < keys[lc]) pick = lc + 1;
          if (mkey <= keys[pick]) break;
          keys[pos]    = keys[pick];
          handles[pos] = handles[pick];
          pos          = pick;
        end
        keys[pos]    = mkey;
        handles[pos] = mhandle;
      end
      r.entry_count = cnt_t'(fill);
      pending_rsps.push_back(r);
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (pending_rsps.size() == 0) begin
        $error("result word with nothing expected: out_key %0h out_handle %0h status %0d",
               got.out_key, got.out_handle, got.status);
        errors++;
        return;
      end
      want = pending_rsps.pop_front();
      if (got.out_key !== want.out_key) begin
        $error("out_key: expected %0h, got %0h", want.out_key, got.out_key);
        errors++;
      end
      if (got.out_handle !== want.out_handle) begin
        $error("out_handle: expected %0h, got %0h", want.out_handle, got.out_handle);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.entry_count !== want.entry_count) begin
        $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  req_t req_i;
  logic busy;
  logic done_o;
  rsp_t rsp_o;

  heap_scoreboard sb;
  int unsigned    cycles = 0;

  // Sender idle percentage for each phase. The third phase is where the
  // receiver would stall, but results cannot be held off, so it runs flat out.
  int unsigned idle_pct[4] = '{0, 51, 0, 20};

  binary_min_heap_queue u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req_i),
    .busy   (busy),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Results are valid for exactly one cycle and are taken at the edge that
  // ends it, so the monitor samples the pre-edge values of done_o and rsp_o.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      sb.check_result(rsp_o);
    end
  end

  function automatic req_t make_word(func_e f, key_t k, handle_t h);
    req_t w;
    w.func         = f;
    w.priority_key = k;
    w.item_handle  = h;
    return w;
  endfunction

  // Keys come from a tiny range a quarter of the time so that ties are common,
  // from the extremes a quarter and the full range otherwise. Pops carry random fields too,
  // since the block must ignore them.
  function automatic req_t rand_word(bit is_pop);
    req_t w;
    w.func = is_pop ? FUNC_POP : FUNC_PUSH;
    case ($urandom_range(0, 3))
      0: w.priority_key = key_t'($urandom_range(0, 3));
      1: w.priority_key = $urandom_range(0, 1) ? '1 : '0;
      default: w.priority_key = key_t'($urandom);
    endcase
    w.item_handle = handle_t'($urandom);
    return w;
  endfunction

  // Offers one word and returns at the edge that accepts it. start stays high
  // from one word to the next unless the sender decides to idle in between.
  task automatic send_word(req_t w, int unsigned pct);
    while ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= w;
    do @(posedge clk_i); while (busy);
    sb.note_word(w);
  endtask

  // Lowers start and holds off until every expected result has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_rsps.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned push_pct;
    start  = 1'b0;
    req_i  = '0;
    rst_ni = 1'b0;
    sb     = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: pop on an empty heap, extreme keys and handles, equal
    // keys whose pop order is fixed by the stop rules, and a drain past empty.
    send_word(make_word(FUNC_POP, '1, '1), 0);
    send_word(make_word(FUNC_PUSH, 16'h1234, '0), 0);
    send_word(make_word(FUNC_PUSH, '1, '1), 0);
    send_word(make_word(FUNC_PUSH, '0, 16'haaaa), 0);
    send_word(make_word(FUNC_PUSH, '0, 16'h5555), 0);
    send_word(make_word(FUNC_PUSH, 16'd8, 16'd1), 0);
    send_word(make_word(FUNC_PUSH, 16'd8, 16'd2), 0);
    send_word(make_word(FUNC_PUSH, 16'd8, 16'd3), 0);
    repeat (8) send_word(make_word(FUNC_POP, '1, '1), 0);

    for (int p = 0; p < 4; p++) begin
      // Random part in chunks with a shifting push bias, so the heap grows
      // deep, shrinks again and now and then runs empty.
      for (int c = 0; c < RAND_WORDS / 10; c++) begin
        case (c % 3)
          0: push_pct = 70;
          1: push_pct = 50;
          default: push_pct = 35;
        endcase
        repeat (10) send_word(rand_word($urandom_range(0, 99) >= push_pct), idle_pct[p]);
      end

      if (p == 2) begin
        // Fill past full so pushes get dropped, toggle around the top, then
        // drain past empty.
        repeat (HEAP_DEPTH + 2) send_word(rand_word(1'b0), idle_pct[p]);
        repeat (4) begin
          send_word(rand_word(1'b1), idle_pct[p]);
          send_word(rand_word(1'b0), idle_pct[p]);
        end
        repeat (HEAP_DEPTH + 2) send_word(rand_word(1'b1), idle_pct[p]);
      end

      // Sender pause between phases: nothing goes in until all is back.
      drain_results();
    end

    repeat (LAT_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_rsps.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
